@@ rtl/tun_pkg.sv @@
package tun_pkg;

    localparam int CB  = 16;            // corner coordinate width, Q8.8
    localparam int OB  = 16;            // normal component width, Q1.14
    localparam int FB  = 14;            // fraction bits of the normal
    localparam int EB  = CB + 1;        // edge vector component
    localparam int PB  = 2 * EB;        // edge product
    localparam int XB  = PB + 1;        // signed cross component
    localparam int MB  = 2 * CB + 1;    // cross component magnitude
    localparam int SPL = (MB + 1) / 2;  // low half of a squared operand
    localparam int HB  = MB - SPL;      // high half
    localparam int SB  = 2 * MB + 2;    // sum of three squares
    localparam int SQ  = SB / 2;        // root bits, one per sqrt stage
    localparam int RB  = SQ + 2;        // sqrt partial remainder
    localparam int QB  = FB + 1;        // quotient bits, one per divide stage
    localparam int NB  = MB + FB;       // scaled numerator

    typedef struct packed {
        logic [SB-1:0]        s;
        logic [SQ-1:0]        q;
        logic [RB-1:0]        r;
        logic [2:0][MB-1:0]   mag;
        logic [2:0]           neg;
    } sqst_t;

    typedef struct packed {
        logic [SQ-1:0]        d;
        logic [2:0][SQ-1:0]   rem;
        logic [2:0][QB-1:0]   lo;
        logic [2:0][QB-1:0]   q;
        logic [2:0]           neg;
        logic                 degen;
    } dvst_t;

endpackage

@@ rtl/tun_if.sv @@
interface tun_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [tun_pkg::CB-1:0]   first_x;
    logic signed [tun_pkg::CB-1:0]   first_y;
    logic signed [tun_pkg::CB-1:0]   first_z;
    logic signed [tun_pkg::CB-1:0]   second_x;
    logic signed [tun_pkg::CB-1:0]   second_y;
    logic signed [tun_pkg::CB-1:0]   second_z;
    logic signed [tun_pkg::CB-1:0]   third_x;
    logic signed [tun_pkg::CB-1:0]   third_y;
    logic signed [tun_pkg::CB-1:0]   third_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    third_x, third_y, third_z, output ready);
endinterface

interface tun_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [tun_pkg::OB-1:0]   normal_x;
    logic signed [tun_pkg::OB-1:0]   normal_y;
    logic signed [tun_pkg::OB-1:0]   normal_z;
    logic                            degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

@@ rtl/triangle_unit_normal.sv @@
// Unit face normal of a triangle, Q8.8 corners in, Q1.14 normal out.
// Pipeline: 58 register stages (6 front, 1 + 34 root, 1 + 15 divide, 1 out). The
// 34-stage square root and the 15-stage restoring divider, one bit per stage, make
// up most of them.
// Throughput: one word per cycle while not stalled; all stages advance together.
// Stall: the whole pipe holds while the output register is full and not taken.
// Reset (rst_n, async low) clears all stage valid bits; data is not reset.
module triangle_unit_normal (
    input  logic      clk,
    input  logic      rst_n,
    tun_in_if.sink    tri_in,
    tun_out_if.source nrm_out
);

    localparam int OB  = tun_pkg::OB;
    localparam int FB  = tun_pkg::FB;
    localparam int EB  = tun_pkg::EB;
    localparam int PB  = tun_pkg::PB;
    localparam int XB  = tun_pkg::XB;
    localparam int MB  = tun_pkg::MB;
    localparam int SPL = tun_pkg::SPL;
    localparam int HB  = tun_pkg::HB;
    localparam int SB  = tun_pkg::SB;
    localparam int SQ  = tun_pkg::SQ;
    localparam int RB  = tun_pkg::RB;
    localparam int QB  = tun_pkg::QB;
    localparam int NB  = tun_pkg::NB;

    logic en;
    logic out_v_reg;

    assign en = !out_v_reg || nrm_out.ready;
    assign tri_in.ready = en;

    // stage valids for the front end
    logic [6:1] fv_reg;

    // stage 1: edges
    logic signed [EB-1:0] u1_reg [3];
    logic signed [EB-1:0] u2_reg [3];
    // stage 2: products
    logic signed [PB-1:0] p_reg [6];
    // stage 3: cross
    logic signed [XB-1:0] c_reg [3];
    // stage 4: magnitude
    logic [MB-1:0] m4_reg [3];
    logic [2:0]    n4_reg;
    // stage 5: partial products of the squares
    logic [2*HB-1:0]    hh_reg [3];
    logic [HB+SPL-1:0]  hl_reg [3];
    logic [2*SPL-1:0]   ll_reg [3];
    logic [MB-1:0]      m5_reg [3];
    logic [2:0]         n5_reg;
    // stage 6: squares
    logic [SB-1:0] s6_reg [3];
    logic [MB-1:0] m6_reg [3];
    logic [2:0]    n6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[5:1], tri_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg[0] <= EB'(tri_in.first_x) - EB'(tri_in.second_x);
            u1_reg[1] <= EB'(tri_in.first_y) - EB'(tri_in.second_y);
            u1_reg[2] <= EB'(tri_in.first_z) - EB'(tri_in.second_z);
            u2_reg[0] <= EB'(tri_in.second_x) - EB'(tri_in.third_x);
            u2_reg[1] <= EB'(tri_in.second_y) - EB'(tri_in.third_y);
            u2_reg[2] <= EB'(tri_in.second_z) - EB'(tri_in.third_z);

            p_reg[0] <= PB'(u1_reg[1]) * PB'(u2_reg[2]);
            p_reg[1] <= PB'(u1_reg[2]) * PB'(u2_reg[1]);
            p_reg[2] <= PB'(u1_reg[2]) * PB'(u2_reg[0]);
            p_reg[3] <= PB'(u1_reg[0]) * PB'(u2_reg[2]);
            p_reg[4] <= PB'(u1_reg[0]) * PB'(u2_reg[1]);
            p_reg[5] <= PB'(u1_reg[1]) * PB'(u2_reg[0]);

            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= XB'(p_reg[2*k]) - XB'(p_reg[2*k+1]);

                n4_reg[k] <= c_reg[k][XB-1];
                m4_reg[k] <= c_reg[k][XB-1] ? MB'(-c_reg[k]) : MB'(c_reg[k]);

                hh_reg[k] <= (2*HB)'(m4_reg[k][MB-1:SPL]) * (2*HB)'(m4_reg[k][MB-1:SPL]);
                hl_reg[k] <= (HB+SPL)'(m4_reg[k][MB-1:SPL]) * (HB+SPL)'(m4_reg[k][SPL-1:0]);
                ll_reg[k] <= (2*SPL)'(m4_reg[k][SPL-1:0]) * (2*SPL)'(m4_reg[k][SPL-1:0]);
                m5_reg[k] <= m4_reg[k];
                n5_reg[k] <= n4_reg[k];

                s6_reg[k] <= (SB'(hh_reg[k]) << (2*SPL)) + (SB'(hl_reg[k]) << (SPL+1))
                           + SB'(ll_reg[k]);
                m6_reg[k] <= m5_reg[k];
                n6_reg[k] <= n5_reg[k];
            end
        end
    end

    // square root, one root bit per stage; stage 0 is loaded with the sum
    tun_pkg::sqst_t sq_reg [SQ+1];
    tun_pkg::sqst_t sq_next [SQ];
    logic [SQ:0]    sv_reg;
    logic [RB-1:0]  sr2 [SQ];
    logic [RB-1:0]  st  [SQ];

    always_comb
    begin
        for (int k = 0; k < SQ; k++)
        begin
            sr2[k] = {sq_reg[k].r[RB-3:0], sq_reg[k].s[SB-1 -: 2]};
            st[k]  = {sq_reg[k].q, 2'b01};
            sq_next[k]     = sq_reg[k];
            sq_next[k].s   = sq_reg[k].s << 2;
            if (sr2[k] >= st[k])
            begin
                sq_next[k].r = sr2[k] - st[k];
                sq_next[k].q = {sq_reg[k].q[SQ-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].r = sr2[k];
                sq_next[k].q = {sq_reg[k].q[SQ-2:0], 1'b0};
            end
        end
    end

    // divider, one quotient bit per stage; stage 0 is loaded from the root
    tun_pkg::dvst_t dv_reg [QB+1];
    tun_pkg::dvst_t dv_next [QB];
    tun_pkg::dvst_t dv_init;
    logic [QB:0]    dvv_reg;
    logic [SQ:0]    dr2 [QB][3];
    logic [NB-1:0]  num [3];

    always_comb
    begin
        dv_init.degen = (sq_reg[SQ].q == '0);
        dv_init.d     = dv_init.degen ? SQ'(1) : sq_reg[SQ].q;
        dv_init.neg   = sq_reg[SQ].neg;
        dv_init.q     = '0;
        for (int j = 0; j < 3; j++)
        begin
            num[j]            = {sq_reg[SQ].mag[j], {FB{1'b0}}};
            dv_init.rem[j]    = SQ'(num[j] >> QB);
            dv_init.lo[j]     = num[j][QB-1:0];
        end
        for (int k = 0; k < QB; k++)
        begin
            dv_next[k] = dv_reg[k];
            for (int j = 0; j < 3; j++)
            begin
                dr2[k][j] = {dv_reg[k].rem[j], dv_reg[k].lo[j][QB-1]};
                dv_next[k].lo[j] = dv_reg[k].lo[j] << 1;
                if (dr2[k][j] >= {1'b0, dv_reg[k].d})
                begin
                    dv_next[k].rem[j] = SQ'(dr2[k][j] - {1'b0, dv_reg[k].d});
                    dv_next[k].q[j]   = {dv_reg[k].q[j][QB-2:0], 1'b1};
                end
                else
                begin
                    dv_next[k].rem[j] = SQ'(dr2[k][j]);
                    dv_next[k].q[j]   = {dv_reg[k].q[j][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg    <= '0;
            dvv_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg    <= {sv_reg[SQ-1:0], fv_reg[6]};
            dvv_reg   <= {dvv_reg[QB-1:0], sv_reg[SQ]};
            out_v_reg <= dvv_reg[QB];
        end
    end

    logic signed [OB-1:0] nx_reg, ny_reg, nz_reg;
    logic                 dg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].s <= s6_reg[0] + s6_reg[1] + s6_reg[2];
            sq_reg[0].q <= '0;
            sq_reg[0].r <= '0;
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[0].mag[j] <= m6_reg[j];
            end
            sq_reg[0].neg <= n6_reg;
            for (int k = 0; k < SQ; k++)
            begin
                sq_reg[k+1] <= sq_next[k];
            end

            dv_reg[0] <= dv_init;
            for (int k = 0; k < QB; k++)
            begin
                dv_reg[k+1] <= dv_next[k];
            end

            nx_reg <= dv_reg[QB].neg[0] ? -OB'(dv_reg[QB].q[0]) : OB'(dv_reg[QB].q[0]);
            ny_reg <= dv_reg[QB].neg[1] ? -OB'(dv_reg[QB].q[1]) : OB'(dv_reg[QB].q[1]);
            nz_reg <= dv_reg[QB].neg[2] ? -OB'(dv_reg[QB].q[2]) : OB'(dv_reg[QB].q[2]);
            dg_reg <= dv_reg[QB].degen;
        end
    end

    assign nrm_out.valid      = out_v_reg;
    assign nrm_out.normal_x   = nx_reg;
    assign nrm_out.normal_y   = ny_reg;
    assign nrm_out.normal_z   = nz_reg;
    assign nrm_out.degenerate = dg_reg;

    // a degenerate triangle must come out with a zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && dg_reg |-> nx_reg == '0 && ny_reg == '0 && nz_reg == '0)
        else $error("degenerate word with nonzero normal");

    // components never exceed one in Q1.14
    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> nx_reg <= OB'(1 << FB) && nx_reg >= -OB'(1 << FB)
                   && ny_reg <= OB'(1 << FB) && ny_reg >= -OB'(1 << FB)
                   && nz_reg <= OB'(1 << FB) && nz_reg >= -OB'(1 << FB))
        else $error("normal component out of range");

    // a valid word leaving the divider reaches the output on the next advance
    assert property (@(posedge clk) disable iff (!rst_n)
        en && dvv_reg[QB] |=> out_v_reg)
        else $error("word lost at output register");

endmodule

@@ tb/sv/tb_triangle_unit_normal.sv @@
module tb_triangle_unit_normal;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = tun_pkg::CB;
    localparam int OB = tun_pkg::OB;
    localparam int FB = tun_pkg::FB;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [CB-1:0] c[9];
    } corners_t;

    typedef struct {
        logic [OB-1:0] nx;
        logic [OB-1:0] ny;
        logic [OB-1:0] nz;
        logic          degen;
    } normal_t;

    logic clk;
    logic rst_n;

    tun_in_if  tri_in ();
    tun_out_if nrm_out ();

    triangle_unit_normal uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tri_in  (tri_in.sink),
        .nrm_out (nrm_out.source)
    );

    normal_t expected_normals[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      quiet;
    bit      hold_req;
    int      hold_left = 0;
    bit      hold_done = 1'b0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // exact floor(sqrt(s)), one root bit per step
    function automatic logic [71:0] floor_root(logic [71:0] s);
        logic [71:0] r;
        logic [71:0] t;
        r = '0;
        for (int i = 35; i >= 0; i--)
        begin
            t = r | (72'd1 << i);
            if (t * t <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic normal_t face_normal(corners_t t);
        longint      p[9];
        longint      e1[3];
        longint      e2[3];
        longint      cr[3];
        logic [71:0] mag[3];
        logic [71:0] s;
        logic [71:0] len;
        logic [71:0] q;
        logic [OB-1:0] comp[3];
        normal_t     n;
        for (int i = 0; i < 9; i++)
            p[i] = longint'(t.c[i]);
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = p[i] - p[3 + i];
            e2[i] = p[3 + i] - p[6 + i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (cr[i] < 0) ? 72'(-cr[i]) : 72'(cr[i]);
            s = s + mag[i] * mag[i];
        end
        n.degen = (s == 0);
        len = n.degen ? 72'd1 : floor_root(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] << FB) / len;
            if (cr[i] < 0)
                q = -q;
            comp[i] = q[OB-1:0];
        end
        n.nx = comp[0];
        n.ny = comp[1];
        n.nz = comp[2];
        return n;
    endfunction

    task automatic send_triangle(corners_t t);
        if (!quiet)
        begin
            while ($urandom_range(99) < 11)
            begin
                tri_in.valid <= 1'b0;
                @(posedge clk);
            end
        end
        tri_in.valid    <= 1'b1;
        tri_in.first_x  <= t.c[0];
        tri_in.first_y  <= t.c[1];
        tri_in.first_z  <= t.c[2];
        tri_in.second_x <= t.c[3];
        tri_in.second_y <= t.c[4];
        tri_in.second_z <= t.c[5];
        tri_in.third_x  <= t.c[6];
        tri_in.third_y  <= t.c[7];
        tri_in.third_z  <= t.c[8];
        forever
        begin
            @(posedge clk);
            if (tri_in.ready)
                break;
        end
        expected_normals.push_back(face_normal(t));
    endtask

    function automatic corners_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                          int c0, int c1, int c2);
        corners_t t;
        t.c[0] = CB'(a0); t.c[1] = CB'(a1); t.c[2] = CB'(a2);
        t.c[3] = CB'(b0); t.c[4] = CB'(b1); t.c[5] = CB'(b2);
        t.c[6] = CB'(c0); t.c[7] = CB'(c1); t.c[8] = CB'(c2);
        return t;
    endfunction

    function automatic corners_t random_tri();
        corners_t t;
        int       mode;
        int       k;
        mode = $urandom_range(9);
        for (int i = 0; i < 9; i++)
        begin
            unique case (mode)
                0, 1, 2, 3: t.c[i] = CB'($urandom);
                4, 5:       t.c[i] = CB'($signed($urandom_range(1023)) - 512);
                6:          t.c[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                default:    t.c[i] = CB'($signed($urandom_range(8191)) - 4096);
            endcase
        end
        if (mode == 7)
        begin
            // collinear: third corner on the line through the first two
            k = $signed($urandom_range(6)) - 3;
            for (int i = 0; i < 3; i++)
                t.c[6 + i] = CB'(int'(t.c[3 + i]) + k * (int'(t.c[3 + i]) - int'(t.c[i])));
        end
        else if (mode == 8)
        begin
            for (int i = 0; i < 3; i++)
                t.c[3 + $urandom_range(1) * 3 + i] = t.c[i];
        end
        return t;
    endfunction

    // receiver hold-off, counted here and read by the ready driver
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && nrm_out.valid && nrm_out.ready)
        begin
            if (expected_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h %h %h %b", nrm_out.normal_x,
                             nrm_out.normal_y, nrm_out.normal_z, nrm_out.degenerate);
            end
            else
            begin
                e = expected_normals.pop_front();
                if (nrm_out.normal_x !== e.nx || nrm_out.normal_y !== e.ny ||
                    nrm_out.normal_z !== e.nz || nrm_out.degenerate !== e.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                                 e.nx, e.ny, e.nz, e.degen, nrm_out.normal_x,
                                 nrm_out.normal_y, nrm_out.normal_z, nrm_out.degenerate);
                end
            end
        end
        if (!rst_n || hold_left > 0)
            nrm_out.ready <= 1'b0;
        else
            nrm_out.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed();
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(256, 0, 0, 0, 0, 0, 0, 256, 0));
        send_triangle(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
        send_triangle(make_tri(0, 0, 256, 0, 0, 0, 256, 0, 0));
        send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_triangle(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
                               32767, 32767, 32767));
        send_triangle(make_tri(32767, -32768, 0, -32768, 32767, 0, 32767, 32767, 0));
        send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                               -32768, 32767, 32767));
        send_triangle(make_tri(32767, 32767, -32768, -32768, 32767, 32767,
                               32767, -32768, 32767));
        send_triangle(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                               -32768, -32768, -32768));
        send_triangle(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
        send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, -3, 7));
        send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(make_tri(0, 0, 0, 1, 1, 0, 1, 0, 1));
        send_triangle(make_tri(-1, -1, -1, 0, 0, 0, 1, 2, 3));
        send_triangle(make_tri(100, -200, 300, -400, 500, -600, 700, 800, -900));
        send_triangle(make_tri(-1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(-32768, 0, 0, 0, 0, 0, 0, -32768, 0));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_triangle(random_tri());
    endtask

    task automatic test_no_idle(int n);
        quiet = 1'b1;
        test_random(n);
        quiet = 1'b0;
    endtask

    task automatic test_output_stall(int n);
        hold_req = 1'b1;
        test_random(n);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        tri_in.valid    = 1'b0;
        tri_in.first_x  = '0;
        tri_in.first_y  = '0;
        tri_in.first_z  = '0;
        tri_in.second_x = '0;
        tri_in.second_y = '0;
        tri_in.second_z = '0;
        tri_in.third_x  = '0;
        tri_in.third_y  = '0;
        tri_in.third_z  = '0;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        test_no_idle(120);
        test_output_stall(130);
        tri_in.valid <= 1'b0;
        while (expected_normals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
